// File: rtl/slet_pkg.sv
// Shared types and constants for the sparse level envelope tracker.
// Holds the command and format codes, the queue entry type and defaults.
// Depends on nothing; every other file imports it.
package slet_pkg;

    // Command codes carried in s_tuser.
    typedef enum logic [1:0] {
        CMD_NEXT  = 2'd0,
        CMD_SCAN  = 2'd1,
        CMD_INIT  = 2'd2,
        CMD_CLOSE = 2'd3
    } cmd_t;

    // Sample format register codes; the unused code converts as unsigned 8-bit.
    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_S16 = 2'd1;
    localparam logic [1:0] FMT_F32 = 2'd2;

    localparam int unsigned FMT_W       = 2;
    localparam int unsigned CMD_W       = 2;
    localparam int unsigned RAW_W       = 32;
    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned SKIP_W      = 7;
    localparam int unsigned SKIP_LOW_W  = 5;

    // Level conversion constants.
    localparam logic [LEVEL_W-1:0] LEVEL_OFFSET = 8'd128;
    localparam logic [LEVEL_W-1:0] LEVEL_POS_MAX = 8'd127;
    localparam logic [LEVEL_W-1:0] LEVEL_NEG_MAX = 8'd128;

    // Skip distance: the next take falls SKIP_BASE + low bits samples later.
    localparam int unsigned        SKIP_BASE   = 80;
    localparam logic [SKIP_W-1:0]  SKIP_RELOAD = SKIP_W'(SKIP_BASE - 1);

    // Reciprocal shift for the averaging divide; exact for sums below 2**14.
    localparam int unsigned DIV_SHIFT = 21;

    // Default configuration of the top level.
    localparam int unsigned AVG_COUNT_DEF   = 10;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // One classified word passed from the front part to the back part.
    typedef struct packed {
        cmd_t                  cmd;
        logic [LEVEL_W-1:0]    abs_level;
        logic [SKIP_LOW_W-1:0] skip_low;
    } entry_t;

endpackage

// File: rtl/slet_front.sv
// Front part: accepts input words, holds the sample format register and
// converts each raw sample to a signed level. Depends on slet_pkg.
module slet_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic [slet_pkg::FMT_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [slet_pkg::RAW_W-1:0]      s_tdata,   // [31:0] sample_raw
    input  logic [slet_pkg::CMD_W-1:0]      s_tuser,   // [1:0] cmd
    input  logic                            q_full,
    output logic                            q_push,
    output slet_pkg::entry_t                q_wdata
);
    import slet_pkg::*;

    logic [FMT_W-1:0]   fmt_reg;
    logic [7:0]         expo;
    logic               neg;
    logic               is_nan;
    logic [8:0]         mag;
    logic [7:0]         mant_top;
    logic [LEVEL_W-1:0] level;

    // Sample format register, written only while the block is idle; unchecked.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_U8;
        end else if (cfg_wen) begin
            fmt_reg <= cfg_wdata;
        end
    end

    // Float fields: only exponents 120..127 give a magnitude between 1 and 255.
    assign expo     = s_tdata[30:23];
    assign neg      = s_tdata[31];
    assign is_nan   = (expo == 8'hFF) && (s_tdata[22:0] != 23'd0);
    assign mant_top = {1'b1, s_tdata[22:16]};

    always_comb begin
        if (expo >= 8'd128) begin
            mag = 9'd256;
        end else if (expo >= 8'd120) begin
            mag = {1'b0, mant_top >> (~expo[2:0])};
        end else begin
            mag = 9'd0;
        end
    end

    // Level conversion by format.
    always_comb begin
        case (fmt_reg)
            FMT_S16: begin
                level = s_tdata[15:8];
            end
            FMT_F32: begin
                if (is_nan) begin
                    level = '0;
                end else if (neg) begin
                    level = (mag >= 9'(LEVEL_NEG_MAX)) ? LEVEL_NEG_MAX
                                                      : LEVEL_W'(-mag[7:0]);
                end else begin
                    level = (mag >= 9'(LEVEL_POS_MAX)) ? LEVEL_POS_MAX : mag[7:0];
                end
            end
            default: begin
                level = s_tdata[7:0] - LEVEL_OFFSET;
            end
        endcase
    end

    // Classified word for the queue.
    assign q_wdata.cmd       = cmd_t'(s_tuser);
    assign q_wdata.abs_level = level[LEVEL_W-1] ? LEVEL_W'(-level) : level;
    assign q_wdata.skip_low  = level[SKIP_LOW_W-1:0];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

// File: rtl/slet_queue.sv
// Short register queue between the front and back parts.
// Holds classified words of type slet_pkg::entry_t; depends on slet_pkg.
module slet_queue #(
    parameter int unsigned DEPTH = slet_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  slet_pkg::entry_t wdata,
    output logic             full,
    output logic             rd_valid,
    output slet_pkg::entry_t rd_data,
    input  logic             pop
);
    import slet_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    entry_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update with explicit wrap.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count exceeds depth");

    a_ptr_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == CNT_W'(DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with empty or full count");

    a_ptr_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0 && count_reg != CNT_W'(DEPTH)) |-> wr_ptr_reg != rd_ptr_reg)
        else $error("queue pointers meet while partly filled");

endmodule

// File: rtl/slet_back.sv
// Back part: skip tracking, level accumulation and averaging, then the
// output register that holds the mouth level. Depends on slet_pkg.
module slet_back #(
    parameter int unsigned AVG_COUNT = slet_pkg::AVG_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  slet_pkg::entry_t              q_rdata,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [slet_pkg::LEVEL_W-1:0]  m_tdata,   // [7:0] mouth_level
    output logic [0:0]                    m_tuser    // [0] level_updated
);
    import slet_pkg::*;

    localparam int unsigned SUM_W   = $clog2(128 * AVG_COUNT + 1);
    localparam int unsigned CNT_W   = $clog2(AVG_COUNT + 1);
    localparam int unsigned RECIP_W = DIV_SHIFT + 1;
    localparam int unsigned PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** DIV_SHIFT) + AVG_COUNT - 1) / AVG_COUNT);

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_CLEAR,
        ACT_UPDATE
    } act_t;

    // Tracker state.
    logic [SUM_W-1:0]   sum_reg,   sum_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SKIP_W-1:0]  skip_reg,  skip_next;

    // Stage A: action and finished sum per word.
    logic               a_valid_reg;
    act_t               a_act_reg, a_act_next;
    logic [SUM_W-1:0]   a_sum_reg, a_sum_next;

    // Stage B: output register.
    logic               b_valid_reg;
    logic [LEVEL_W-1:0] mouth_reg;
    logic               upd_reg;

    logic               b_load;
    logic               a_load;
    logic               take;
    logic [SUM_W-1:0]   sum_add;
    logic [CNT_W-1:0]   count_inc;
    logic [PROD_W-1:0]  prod;

    assign b_load = !b_valid_reg || m_tready;
    assign a_load = q_valid && (!a_valid_reg || b_load);
    assign q_pop  = a_load;

    // State update for the word leaving the queue.
    assign take      = (q_rdata.cmd == CMD_SCAN) || (skip_reg == '0);
    assign sum_add   = sum_reg + SUM_W'(q_rdata.abs_level);
    assign count_inc = count_reg + 1'b1;

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        skip_next  = skip_reg;
        a_act_next = ACT_HOLD;
        a_sum_next = sum_add;
        case (q_rdata.cmd)
            CMD_INIT: begin
                sum_next   = '0;
                count_next = '0;
                skip_next  = '0;
                a_act_next = ACT_CLEAR;
            end
            CMD_CLOSE: begin
                a_act_next = ACT_CLEAR;
            end
            default: begin
                if (!take) begin
                    skip_next = skip_reg - 1'b1;
                end else begin
                    skip_next = SKIP_RELOAD + SKIP_W'(q_rdata.skip_low);
                    if (count_inc >= CNT_W'(AVG_COUNT)) begin
                        sum_next   = '0;
                        count_next = '0;
                        a_act_next = ACT_UPDATE;
                    end else begin
                        sum_next   = sum_add;
                        count_next = count_inc;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            count_reg   <= '0;
            skip_reg    <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            if (a_load) begin
                sum_reg     <= sum_next;
                count_reg   <= count_next;
                skip_reg    <= skip_next;
                a_valid_reg <= 1'b1;
            end else if (b_load) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_act_reg <= a_act_next;
            a_sum_reg <= a_sum_next;
        end
    end

    // Divide by AVG_COUNT as a multiply by its scaled reciprocal.
    assign prod = PROD_W'(a_sum_reg) * PROD_W'(RECIP);

    // Output stage holds the mouth value; it moves only when empty or taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            mouth_reg   <= '0;
            upd_reg     <= 1'b0;
        end else if (b_load) begin
            b_valid_reg <= a_valid_reg;
            if (a_valid_reg) begin
                case (a_act_reg)
                    ACT_CLEAR: begin
                        mouth_reg <= '0;
                        upd_reg   <= 1'b0;
                    end
                    ACT_UPDATE: begin
                        mouth_reg <= prod[DIV_SHIFT +: LEVEL_W];
                        upd_reg   <= 1'b1;
                    end
                    default: begin
                        upd_reg   <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = mouth_reg;
    assign m_tuser  = upd_reg;

    a_mouth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mouth_reg <= LEVEL_W'(128))
        else $error("mouth level above 128");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg < CNT_W'(AVG_COUNT))
        else $error("taken count reached the average length without clearing");

    a_skip_range: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_reg <= SKIP_RELOAD + SKIP_W'(31))
        else $error("skip distance out of range");

    a_sum_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("level sum nonzero with no samples taken");

endmodule

// File: rtl/sparse_level_envelope_tracker_unit.sv
// An accepted word passes through the queue, then stage A, then the output stage to m_tvalid.
// Throughput: one word per cycle sustained while m_tready is high; s_tready comes only
// from the queue fill count, so it never follows m_tready in the same cycle. A stalled
// result blocks intake once both back stages and all queue entries are full.
// The averaging divide is one reciprocal multiply in the output stage.
// Reset (aresetn low, synchronous) clears the format register, the queue, the
// level sum, taken count, skip count and mouth level; no clearing pass follows.
module sparse_level_envelope_tracker_unit #(
    parameter int unsigned AVG_COUNT   = slet_pkg::AVG_COUNT_DEF,
    parameter int unsigned QUEUE_DEPTH = slet_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [slet_pkg::FMT_W-1:0]    cfg_wdata,  // [1:0] sample_format
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [slet_pkg::RAW_W-1:0]    s_tdata,    // [31:0] sample_raw
    input  logic [slet_pkg::CMD_W-1:0]    s_tuser,    // [1:0] cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [slet_pkg::LEVEL_W-1:0]  m_tdata,    // [7:0] mouth_level
    output logic [0:0]                    m_tuser     // [0] level_updated
);
    import slet_pkg::*;

    logic   q_full;
    logic   q_push;
    entry_t q_wdata;
    logic   q_valid;
    entry_t q_rdata;
    logic   q_pop;

    // Intake and level conversion.
    slet_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    // Queue between the two parts.
    slet_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wdata    (q_wdata),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_data  (q_rdata),
        .pop      (q_pop)
    );

    // Skip tracking, averaging and output register.
    slet_back #(
        .AVG_COUNT (AVG_COUNT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: sim/sparse_level_envelope_tracker_unit_test.sv
// Self-checking testbench for sparse_level_envelope_tracker_unit.
// It runs a directed table, then random phases with a bit-exact mouth level predictor.
// It depends only on slet_pkg and the unit itself.
module sparse_level_envelope_tracker_unit_test;
    import slet_pkg::*;

    localparam int AVG_TAKES  = 10;
    localparam int TAKE_GAP   = 80;
    localparam int RUN_LIMIT  = 200000;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_LEN  = 125;
    localparam int NUM_ROWS   = 25;

    // One expected result word: mouth level and the update flag.
    typedef struct packed {
        logic [7:0] level;
        logic       upd;
    } mouth_report_t;

    // One directed stimulus row; typed rows carry their own expected result.
    typedef struct packed {
        logic [1:0] fmt;
        cmd_t       cmd;
        logic [31:0] raw;
        bit         typed;
        logic [7:0] level;
        bit         upd;
    } script_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [1:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;

    // Predictor state, mirroring the unit's registers.
    logic [1:0]  fmt_now = FMT_U8;
    logic [15:0] sum_acc = '0;
    logic [6:0]  takes = '0;
    logic [6:0]  skip_left = '0;
    logic [7:0]  mouth_now = '0;

    mouth_report_t mouth_expected_q[$];
    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  idle_off = 1'b0;

    // Extremes of each format, every command and the float special values.
    script_row_t script_rows [NUM_ROWS] = '{
        '{FMT_U8,  CMD_NEXT,  32'h0000_0000, 1'b1, 8'd0,   1'b0},
        '{FMT_U8,  CMD_NEXT,  32'h0000_00FF, 1'b1, 8'd0,   1'b0},
        '{FMT_U8,  CMD_SCAN,  32'h0000_0000, 1'b0, 8'd0,   1'b0},
        '{FMT_U8,  CMD_SCAN,  32'h0000_0000, 1'b0, 8'd0,   1'b0},
        '{FMT_U8,  CMD_SCAN,  32'h0000_0000, 1'b0, 8'd0,   1'b0},
        '{FMT_U8,  CMD_SCAN,  32'h0000_0000, 1'b0, 8'd0,   1'b0},
        '{FMT_U8,  CMD_SCAN,  32'h0000_0000, 1'b0, 8'd0,   1'b0},
        '{FMT_U8,  CMD_SCAN,  32'h0000_0000, 1'b0, 8'd0,   1'b0},
        '{FMT_U8,  CMD_SCAN,  32'h0000_0000, 1'b0, 8'd0,   1'b0},
        '{FMT_U8,  CMD_SCAN,  32'h0000_0000, 1'b0, 8'd0,   1'b0},
        '{FMT_U8,  CMD_SCAN,  32'hFFFF_FF00, 1'b1, 8'd128, 1'b1},
        '{FMT_U8,  CMD_CLOSE, 32'hFFFF_FFFF, 1'b1, 8'd0,   1'b0},
        '{FMT_U8,  CMD_INIT,  32'hFFFF_FFFF, 1'b1, 8'd0,   1'b0},
        '{FMT_S16, CMD_SCAN,  32'h0000_7FFF, 1'b0, 8'd0,   1'b0},
        '{FMT_S16, CMD_SCAN,  32'hFFFF_8000, 1'b0, 8'd0,   1'b0},
        '{FMT_S16, CMD_NEXT,  32'h0000_1234, 1'b0, 8'd0,   1'b0},
        '{FMT_F32, CMD_SCAN,  32'h7FC0_0000, 1'b0, 8'd0,   1'b0},
        '{FMT_F32, CMD_SCAN,  32'h7F80_0000, 1'b0, 8'd0,   1'b0},
        '{FMT_F32, CMD_SCAN,  32'hFF80_0000, 1'b0, 8'd0,   1'b0},
        '{FMT_F32, CMD_SCAN,  32'h0000_0001, 1'b0, 8'd0,   1'b0},
        '{FMT_F32, CMD_SCAN,  32'h3B80_0000, 1'b0, 8'd0,   1'b0},
        '{FMT_F32, CMD_SCAN,  32'hBF00_0000, 1'b0, 8'd0,   1'b0},
        '{FMT_F32, CMD_SCAN,  32'h3F7F_FFFF, 1'b0, 8'd0,   1'b0},
        '{2'd3,    CMD_SCAN,  32'h1234_56FF, 1'b0, 8'd0,   1'b0},
        '{2'd3,    CMD_SCAN,  32'h0000_0080, 1'b0, 8'd0,   1'b0}
    };

    sparse_level_envelope_tracker_unit #(
        .AVG_COUNT(AVG_TAKES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wen(cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Signed 8-bit level of one raw sample under the given format.
    function automatic int sample_level(logic [1:0] f, logic [31:0] raw);
        int          mag;
        int unsigned sh;
        logic [7:0]  ex;
        logic [22:0] fr;
        logic [23:0] mant;
        if (f == FMT_S16) begin
            return $signed(raw[15:8]);
        end
        if (f != FMT_F32) begin
            return int'(raw[7:0]) - 128;
        end
        ex = raw[30:23];
        fr = raw[22:0];
        // NaN reads as silence; exponents from 128 up saturate.
        if (ex == 8'hFF && fr != '0) begin
            return 0;
        end
        if (ex == 8'd0) begin
            mag = 0;
        end else if (ex >= 8'd128) begin
            mag = 256;
        end else begin
            sh = 143 - int'(ex);
            mant = {1'b1, fr};
            mag = (sh >= 32) ? 0 : int'(mant >> sh);
        end
        if (raw[31]) begin
            return (mag >= 128) ? -128 : -mag;
        end
        return (mag >= 127) ? 127 : mag;
    endfunction

    // Advances the predicted state by one word and returns the expected result.
    function automatic mouth_report_t track_mouth(cmd_t c, logic [31:0] raw);
        mouth_report_t r;
        int            lvl;
        int            absv;
        r.upd = 1'b0;
        case (c)
            CMD_INIT: begin
                sum_acc = '0;
                takes = '0;
                skip_left = '0;
                mouth_now = '0;
            end
            CMD_CLOSE: begin
                mouth_now = '0;
            end
            default: begin
                if (c == CMD_NEXT && skip_left != '0) begin
                    skip_left = skip_left - 7'd1;
                end else begin
                    lvl = sample_level(fmt_now, raw);
                    absv = (lvl < 0) ? -lvl : lvl;
                    sum_acc = sum_acc + 16'(absv);
                    skip_left = 7'(TAKE_GAP - 1 + (lvl & 'h1F));
                    takes = takes + 7'd1;
                    if (int'(takes) >= AVG_TAKES) begin
                        mouth_now = 8'(int'(sum_acc) / AVG_TAKES);
                        sum_acc = '0;
                        takes = '0;
                        r.upd = 1'b1;
                    end
                end
            end
        endcase
        r.level = mouth_now;
        return r;
    endfunction

    // Offers one word, with an occasional gap first, and records its expectation.
    task automatic send_word(cmd_t c, logic [31:0] raw, bit typed, mouth_report_t typed_exp);
        int            gap;
        mouth_report_t pred;
        if (!idle_off && $urandom_range(0, 11) == 0) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= raw;
        s_tuser <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = track_mouth(c, raw);
        mouth_expected_q.insert(mouth_expected_q.size(), typed ? typed_exp : pred);
    endtask

    // Stops the input and waits until every expected word has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (mouth_expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_format(logic [1:0] f);
        cfg_wen <= 1'b1;
        cfg_wdata <= f;
        @(posedge aclk);
        fmt_now = f;
        cfg_wen <= 1'b0;
    endtask

    // Random sample bits; float phases mostly get values in the useful range.
    function automatic logic [31:0] random_raw(logic [1:0] f);
        logic [31:0] specials [7] = '{32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
                                      32'h0000_0000, 32'h8000_0000, 32'h007F_FFFF,
                                      32'h4300_0000};
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick == 9) begin
            return specials[$urandom_range(0, 6)];
        end
        if (f == FMT_F32 && pick < 6) begin
            return {1'($urandom_range(0, 1)), 8'($urandom_range(110, 135)), 23'($urandom)};
        end
        return $urandom;
    endfunction

    function automatic cmd_t random_cmd(int scan_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 1) begin
            return CMD_INIT;
        end
        if (pick < 2) begin
            return CMD_CLOSE;
        end
        if (pick < 2 + scan_pct) begin
            return CMD_SCAN;
        end
        return CMD_NEXT;
    endfunction

    // Result side: random stall bursts on m_tready and the in-order compare.
    initial begin
        int            stall_left;
        mouth_report_t want;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (mouth_expected_q.size() == 0) begin
                    $display("%0t: unexpected word, level %0d updated %0d",
                             $time, m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    want = mouth_expected_q.pop_front();
                    if (m_tdata !== want.level) begin
                        $display("%0t: mouth level expected %0d actual %0d",
                                 $time, want.level, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tuser[0] !== want.upd) begin
                        $display("%0t: level updated expected %0d actual %0d",
                                 $time, want.upd, m_tuser[0]);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left != 0 && !idle_off) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 19) == 0) begin
                stall_left = $urandom_range(0, 14);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("sparse_level_envelope_tracker_unit regression: fail");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, final report.
    initial begin
        logic [1:0] phase_fmt [4];
        logic [1:0] f;
        int         scan_pct;
        mouth_report_t typed_exp;
        phase_fmt = '{FMT_F32, FMT_S16, 2'd3, FMT_U8};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            if (i == 0 || script_rows[i].fmt != fmt_now) begin
                drain_results();
                write_format(script_rows[i].fmt);
            end
            typed_exp.level = script_rows[i].level;
            typed_exp.upd = script_rows[i].upd;
            send_word(script_rows[i].cmd, script_rows[i].raw, script_rows[i].typed, typed_exp);
        end

        // Phases alternate sparse scans, which let the skip count run out,
        // with frequent scans, which complete averages quickly.
        typed_exp = '0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            f = (p < 4) ? phase_fmt[p] : 2'($urandom_range(0, 3));
            drain_results();
            write_format(f);
            idle_off = (p == NUM_PHASES - 1) || ($urandom_range(0, 3) == 0);
            scan_pct = (p % 2 == 0) ? 3 : 40;
            for (int n = 0; n < PHASE_LEN; n++) begin
                send_word(random_cmd(scan_pct), random_raw(f), 1'b0, typed_exp);
            end
        end

        s_tvalid <= 1'b0;
        while (mouth_expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("sparse_level_envelope_tracker_unit regression: pass");
        end else begin
            $display("sparse_level_envelope_tracker_unit regression: fail");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/slet_pkg.sv
rtl/slet_front.sv
rtl/slet_queue.sv
rtl/slet_back.sv
rtl/sparse_level_envelope_tracker_unit.sv
sim/sparse_level_envelope_tracker_unit_test.sv
